FILE: src/assert_macros.svh
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dq_pkg.sv
// Types and constants shared by the double-ended queue RTL.
// Depends on nothing; imported by every module of the block.
package dq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int OP_W               = 3;
   localparam int DATA_W             = 32;
   localparam int COUNT_W            = 5;

   // Operation codes carried in the op field of a request beat.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   // Command broadcast to every cell of one row.
   typedef enum logic [1:0] {
      CMD_HOLD      = 2'd0,
      CMD_SHIFT_IN  = 2'd1,
      CMD_APPEND    = 2'd2,
      CMD_SHIFT_OUT = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     error;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

FILE: src/dq_cell.sv
// One storage cell of a queue row: holds a word and takes it from a neighbour.
// Depends on dq_pkg for the row command type.
module dq_cell #(
   parameter int WORD_WIDTH = dq_pkg::WORD_WIDTH_DEFAULT,
   parameter int CNT_W      = $clog2(dq_pkg::DEPTH_DEFAULT + 1),
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  dq_pkg::cell_cmd_type    cmd,
   input  logic [CNT_W-1:0]        fill_count,
   input  logic [WORD_WIDTH-1:0]   fill_word,
   input  logic [WORD_WIDTH-1:0]   prev_word,
   input  logic [WORD_WIDTH-1:0]   next_word,
   output logic [WORD_WIDTH-1:0]   word_out
);
   import dq_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   // An append lands in the first free cell, which is the one whose index
   // equals the current fill.
   always_comb begin
      word_in = word_ff;
      unique case (cmd)
         CMD_HOLD: begin
            word_in = word_ff;
         end
         CMD_SHIFT_IN: begin
            word_in = prev_word;
         end
         CMD_APPEND: begin
            if (fill_count == CNT_W'(INDEX)) begin
               word_in = fill_word;
            end
         end
         CMD_SHIFT_OUT: begin
            word_in = next_word;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

FILE: src/dq_row.sv
// A row of DEPTH cells kept packed towards cell 0, which is the row's top.
// Depends on dq_pkg and dq_cell.
module dq_row #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = dq_pkg::WORD_WIDTH_DEFAULT,
   parameter int CNT_W      = $clog2(dq_pkg::DEPTH_DEFAULT + 1)
) (
   input  logic                    clock,
   input  dq_pkg::cell_cmd_type    cmd,
   input  logic [CNT_W-1:0]        fill_count,
   input  logic [WORD_WIDTH-1:0]   fill_word,
   output logic [WORD_WIDTH-1:0]   top_word
);
   import dq_pkg::*;

   logic [WORD_WIDTH-1:0] cell_word [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] prev_word;
      logic [WORD_WIDTH-1:0] next_word;

      // The top cell takes the new word on a shift in; the bottom cell
      // takes don't-care data on a shift out, as it is then beyond the fill.
      if (i == 0) begin : g_top
         assign prev_word = fill_word;
      end else begin : g_inner_prev
         assign prev_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign next_word = '0;
      end else begin : g_inner_next
         assign next_word = cell_word[i+1];
      end

      dq_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .fill_count (fill_count),
         .fill_word  (fill_word),
         .prev_word  (prev_word),
         .next_word  (next_word),
         .word_out   (cell_word[i])
      );
   end

   assign top_word = cell_word[0];

endmodule

FILE: src/double_ended_queue_core.sv
// Double-ended queue of signed words: top level with handshakes and control.
// Depends on dq_pkg, dq_row (and dq_cell below it) and assert_macros.svh.
//
// This block is a bounded double-ended queue of up to DEPTH words, each stored
// as its low WORD_WIDTH bits. Every request beat carries one operation: push
// at the front, push at the rear, pop the front, pop the rear, or peek at
// either end. Exactly one response beat comes back for every request beat,
// in order, carrying the popped or peeked word (zero for pushes, on error and
// for the unused op codes six and seven), an error flag and the number of
// entries held after the operation. A pop or peek on an empty queue, or a
// push on a full one, sets the error flag and leaves the queue as it was.
// The block accepts one request beat per clock cycle and presents its
// response in an output register on the following cycle; a new request is
// taken while the previous response is being taken, and req_stall is raised
// only while a response waits and the consumer is stalling it. That rate is
// set by the two rows of storage cells, each of which shifts by one place or
// writes one cell for each operation. Storage is two rows of DEPTH cells:
// the front row holds the queue with its front word in cell 0, and the rear
// row holds the same words in reverse order with the rear word in cell 0, so
// that both ends are always read from a fixed cell. A push at one end shifts
// that end's row and appends to the other row at the position given by the
// fill count; a pop shifts one row and simply shortens the other. Stored
// words need no clearing after reset: only the entry count and the response
// valid flag are reset, and no cell beyond the fill is ever read.
`include "assert_macros.svh"

module double_ended_queue_core #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = dq_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [WORD_WIDTH-1:0] push_word;
   logic [WORD_WIDTH-1:0] front_word;
   logic [WORD_WIDTH-1:0] rear_word;

   cell_cmd_type          front_cmd;
   cell_cmd_type          rear_cmd;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   // A beat is taken unless a response is still waiting and being stalled.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // The pushed word keeps its low bits as plain bits, never sign-extended.
   assign push_word = WORD_WIDTH'($unsigned(req_data.value));

   // Decode the operation into row commands, the next count and the response.
   always_comb begin
      front_cmd         = CMD_HOLD;
      rear_cmd          = CMD_HOLD;
      count_in          = count_ff;
      rsp_data_in.data  = '0;
      rsp_data_in.error = 1'b0;

      if (accept) begin
         unique case (req_data.op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  front_cmd = CMD_SHIFT_IN;
                  rear_cmd  = CMD_APPEND;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_PUSH_REAR: begin
               if (full) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  front_cmd = CMD_APPEND;
                  rear_cmd  = CMD_SHIFT_IN;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  // The rear row loses its last word simply by the count
                  // going down.
                  front_cmd        = CMD_SHIFT_OUT;
                  count_in         = count_ff - 1'b1;
                  rsp_data_in.data = DATA_W'(front_word);
               end
            end
            OP_POP_REAR: begin
               if (empty) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  rear_cmd         = CMD_SHIFT_OUT;
                  count_in         = count_ff - 1'b1;
                  rsp_data_in.data = DATA_W'(rear_word);
               end
            end
            OP_PEEK_FRONT: begin
               if (empty) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  rsp_data_in.data = DATA_W'(front_word);
               end
            end
            OP_PEEK_REAR: begin
               if (empty) begin
                  rsp_data_in.error = 1'b1;
               end else begin
                  rsp_data_in.data = DATA_W'(rear_word);
               end
            end
            default: begin
               // Unused op codes leave the queue alone and report no error.
            end
         endcase
      end

      rsp_data_in.count = COUNT_W'(count_in);
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   dq_row #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
   ) u_front_row (
      .clock      (clock),
      .cmd        (front_cmd),
      .fill_count (count_ff),
      .fill_word  (push_word),
      .top_word   (front_word)
   );

   dq_row #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
   ) u_rear_row (
      .clock      (clock),
      .cmd        (rear_cmd),
      .fill_count (count_ff),
      .fill_word  (push_word),
      .top_word   (rear_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A successful push grows the queue by exactly one entry.
   `DQ_ASSERT(a_push_grows, clock, reset, accept && !full && (req_data.op == OP_PUSH_FRONT || req_data.op == OP_PUSH_REAR) |=> count_ff == CNT_W'($past(count_ff) + 1'b1), "successful push did not raise the entry count by one")

   // Reading an empty queue must be flagged in the response that follows.
   `DQ_ASSERT(a_empty_read_flagged, clock, reset, accept && empty && (req_data.op == OP_POP_FRONT || req_data.op == OP_POP_REAR || req_data.op == OP_PEEK_FRONT || req_data.op == OP_PEEK_REAR) |=> rsp_valid_ff && rsp_data_ff.error, "read of an empty queue was not flagged")

   // An error response never carries a word.
   `DQ_ASSERT(a_error_no_data, clock, reset, rsp_valid_ff && rsp_data_ff.error |-> rsp_data_ff.data == '0, "error response carries non-zero data")

   // A waiting response always reports the count that the queue holds now.
   `DQ_ASSERT(a_count_tracks, clock, reset, rsp_valid_ff |-> rsp_data_ff.count == COUNT_W'(count_ff), "response count differs from the entry count")

   // The entry count never passes the depth of the rows.
   `DQ_ASSERT_ALWAYS(a_count_bounded, clock, count_ff <= CNT_W'(DEPTH) || $past(reset) || reset, "entry count beyond the queue depth")

endmodule
